// ===== rtl/core/stx_etx_bcc_frame_checker_defines.svh =====
// assertion macros for the stx/etx bcc frame checker
`ifndef STX_ETX_BCC_FRAME_CHECKER_DEFINES_SVH
`define STX_ETX_BCC_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SEBFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// next-cycle implication, checked outside reset
`define SEBFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// ===== rtl/core/sebfc_pkg.sv =====
// shared types and character constants for the stx/etx bcc frame checker
package sebfc_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned PAD_W  = 4;

  localparam logic [CHAR_W-1:0] CH_STX  = 7'h02;
  localparam logic [CHAR_W-1:0] CH_ETX  = 7'h03;
  localparam logic [CHAR_W-1:0] CH_NAK  = 7'd21;
  localparam logic [CHAR_W-1:0] CH_AT   = 7'h40;
  localparam logic [CHAR_W-1:0] CH_STAR = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT  = 7'h2E;

  localparam logic [PAD_W-1:0] PAD_SHORT = 4'd3;
  localparam logic [PAD_W-1:0] PAD_LONG  = 4'd9;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_BCC  = 2'd2,
    PH_PAD  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BODY     = 3'd1,
    EV_GOOD     = 3'd2,
    EV_MISMATCH = 3'd3,
    EV_NOETX    = 3'd4,
    EV_NAK      = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] body_char;
    event_kind_t       event_kind;
  } result_t;

endpackage

// ===== rtl/core/stx_etx_bcc_frame_checker.sv =====
// top level of the stx/etx bcc frame checker with input and result registers
//
// Checks received 7-bit characters against frames of the form STX, body, ETX,
// BCC (7-bit sum of body and ETX), with 3 trailing ETX owed after a BCC of '@'
// and 9 after '*' or '.'. Every accepted character gives exactly one result
// transfer: none, body char, frame good, bcc mismatch, missing etx or nak.
// One character per clock is taken while the result side does not stall; a
// result passes the input register, then the result register. The rate is set
// by the frame state update, which is registered once per accepted character.
// A stalled result register holds one result while the input register takes
// one more character before in_tready falls.
`include "stx_etx_bcc_frame_checker_defines.svh"

module stx_etx_bcc_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] rx_char, [7] zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] event_kind, [9:3] body_char, [15:10] zero
);

  logic                         s1_valid_r;
  logic [sebfc_pkg::CHAR_W-1:0] s1_char_r;
  logic                         out_valid_r;
  sebfc_pkg::result_t           out_result_r;
  sebfc_pkg::result_t           step_result;
  logic                         out_open;
  logic                         s1_move;

  assign out_open  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_open;
  assign in_tready = !s1_valid_r || out_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata[sebfc_pkg::CHAR_W-1:0];
    end
  end

  sebfc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_move),
    .rx_char (s1_char_r),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_result_r.body_char, out_result_r.event_kind};

  `SEBFC_ASSERT_NOW(a_body_char_zero, out_tvalid && (out_result_r.event_kind != sebfc_pkg::EV_BODY), out_result_r.body_char == '0)
  `SEBFC_ASSERT_NOW(a_kind_range, out_tvalid, out_tdata[2:0] <= 3'(sebfc_pkg::EV_NAK))
  `SEBFC_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r && !out_tready)
  `SEBFC_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid_r)

endmodule

// ===== rtl/core/sebfc_fsm.sv =====
// frame state machine: phase, running sum, received bcc and trailing etx count
module sebfc_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [sebfc_pkg::CHAR_W-1:0] rx_char,
  output sebfc_pkg::result_t           result
);

  sebfc_pkg::phase_t             phase_r, phase_nxt;
  logic [sebfc_pkg::CHAR_W-1:0]  sum_r, sum_nxt;
  logic [sebfc_pkg::CHAR_W-1:0]  check_r, check_nxt;
  logic [sebfc_pkg::PAD_W-1:0]   pad_r, pad_nxt;

  logic is_etx;
  logic long_pad;
  logic pad_done;

  assign is_etx   = (rx_char == sebfc_pkg::CH_ETX);
  assign long_pad = (rx_char == sebfc_pkg::CH_STAR) || (rx_char == sebfc_pkg::CH_DOT);
  // an unreachable zero count is taken as the last owed etx
  assign pad_done = (pad_r <= sebfc_pkg::PAD_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sebfc_pkg::PH_HUNT;
      sum_r   <= '0;
      check_r <= '0;
      pad_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      check_r <= check_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    check_nxt = check_r;
    pad_nxt   = pad_r;
    unique case (phase_r)
      sebfc_pkg::PH_HUNT: begin
        if (rx_char == sebfc_pkg::CH_STX) begin
          sum_nxt   = '0;
          phase_nxt = sebfc_pkg::PH_BODY;
        end
      end
      sebfc_pkg::PH_BODY: begin
        sum_nxt = sum_r + rx_char;
        if (is_etx) begin
          phase_nxt = sebfc_pkg::PH_BCC;
        end
      end
      sebfc_pkg::PH_BCC: begin
        check_nxt = rx_char;
        if (rx_char == sebfc_pkg::CH_AT) begin
          pad_nxt   = sebfc_pkg::PAD_SHORT;
          phase_nxt = sebfc_pkg::PH_PAD;
        end else if (long_pad) begin
          pad_nxt   = sebfc_pkg::PAD_LONG;
          phase_nxt = sebfc_pkg::PH_PAD;
        end else begin
          phase_nxt = sebfc_pkg::PH_HUNT;
          pad_nxt   = '0;
        end
      end
      sebfc_pkg::PH_PAD: begin
        if (!is_etx || pad_done) begin
          phase_nxt = sebfc_pkg::PH_HUNT;
          pad_nxt   = '0;
        end else begin
          pad_nxt = pad_r - sebfc_pkg::PAD_W'(1);
        end
      end
      default: begin
        phase_nxt = sebfc_pkg::PH_HUNT;
      end
    endcase
  end

  // result for the current character
  always_comb begin
    result.event_kind = sebfc_pkg::EV_NONE;
    result.body_char  = '0;
    unique case (phase_r)
      sebfc_pkg::PH_HUNT: begin
        if (rx_char == sebfc_pkg::CH_NAK) begin
          result.event_kind = sebfc_pkg::EV_NAK;
        end
      end
      sebfc_pkg::PH_BODY: begin
        if (!is_etx) begin
          result.event_kind = sebfc_pkg::EV_BODY;
          result.body_char  = rx_char;
        end
      end
      sebfc_pkg::PH_BCC: begin
        // the bcc itself is judged at once when no trailing etx is owed
        if ((rx_char != sebfc_pkg::CH_AT) && !long_pad) begin
          result.event_kind = (rx_char == sebfc_pkg::CHAR_W'(sum_r)) ?
                              sebfc_pkg::EV_GOOD : sebfc_pkg::EV_MISMATCH;
        end
      end
      sebfc_pkg::PH_PAD: begin
        if (!is_etx) begin
          result.event_kind = sebfc_pkg::EV_NOETX;
        end else if (pad_done) begin
          result.event_kind = (check_r == sum_r) ?
                              sebfc_pkg::EV_GOOD : sebfc_pkg::EV_MISMATCH;
        end
      end
      default: begin
        result.event_kind = sebfc_pkg::EV_NONE;
      end
    endcase
  end

endmodule

// ===== tb/tb_stx_etx_bcc_frame_checker.sv =====
// testbench for the stx/etx bcc frame checker: directed and random frames against a predictor
module tb_stx_etx_bcc_frame_checker;
  import sebfc_pkg::*;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [6:0] rx_char, [7] zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [2:0] event_kind, [9:3] body_char, [15:10] zero

  // predictor copy of the frame state
  phase_t            fc_phase = PH_HUNT;
  logic [CHAR_W-1:0] fc_sum   = '0;
  logic [CHAR_W-1:0] fc_check = '0;
  logic [PAD_W-1:0]  fc_owed  = '0;

  result_t pending_events[$];
  int      chars_sent     = 0;
  int      mismatch_count = 0;
  int      events_seen[6];
  bit      in_idle_on     = 1'b0;
  bit      out_stall_on   = 1'b0;

  stx_etx_bcc_frame_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_stx_etx_bcc_frame_checker failed");
    $finish;
  end

  task close_frame(output event_kind_t ev);
    if (fc_check == fc_sum) ev = EV_GOOD;
    else ev = EV_MISMATCH;
    fc_phase = PH_HUNT;
    fc_owed  = '0;
  endtask

  task predict_frame_event(input logic [CHAR_W-1:0] c, output result_t r);
    event_kind_t ev;
    r.event_kind = EV_NONE;
    r.body_char  = '0;
    case (fc_phase)
      PH_HUNT: begin
        if (c == CH_NAK) begin
          r.event_kind = EV_NAK;
        end else if (c == CH_STX) begin
          fc_sum   = '0;
          fc_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        fc_sum = fc_sum + c;
        if (c == CH_ETX) begin
          fc_phase = PH_BCC;
        end else begin
          r.event_kind = EV_BODY;
          r.body_char  = c;
        end
      end
      PH_BCC: begin
        fc_check = c;
        if (c == CH_AT) begin
          fc_owed  = PAD_SHORT;
          fc_phase = PH_PAD;
        end else if (c == CH_STAR || c == CH_DOT) begin
          fc_owed  = PAD_LONG;
          fc_phase = PH_PAD;
        end else begin
          close_frame(ev);
          r.event_kind = ev;
        end
      end
      default: begin
        if (c != CH_ETX) begin
          r.event_kind = EV_NOETX;
          fc_phase     = PH_HUNT;
          fc_owed      = '0;
        end else if (fc_owed <= 1) begin
          close_frame(ev);
          r.event_kind = ev;
        end else begin
          fc_owed = fc_owed - 1'b1;
        end
      end
    endcase
  endtask

  // result checking first, then prediction for the character taken at this edge
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[9:0]);
        if (pending_events.size() == 0) begin
          $error("event_kind: expected no transfer, got %0d", got.event_kind);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          events_seen[want.event_kind]++;
          if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
            mismatch_count++;
          end
          if (got.body_char !== want.body_char) begin
            $error("body_char: expected %0h, got %0h", want.body_char, got.body_char);
            mismatch_count++;
          end
          if (out_tdata[15:10] !== 6'd0) begin
            $error("zero fill: expected 0, got %0h", out_tdata[15:10]);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_frame_event(in_tdata[CHAR_W-1:0], want);
        pending_events.push_back(want);
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (out_stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task send_char(input logic [CHAR_W-1:0] c);
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, c};
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task send_chars(input char_q_t q);
    foreach (q[i]) send_char(q[i]);
  endtask

  // one frame, a burst of line noise, or a frame cut off after its body
  task gen_frame(output char_q_t q);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] sum;
    logic [CHAR_W-1:0] target;
    logic [CHAR_W-1:0] bcc;
    int                mode;
    int                pads;
    q    = {};
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      repeat ($urandom_range(1, 6)) begin
        c = CHAR_W'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) c = CH_NAK;
        q.push_back(c);
      end
    end else begin
      q.push_back(CH_STX);
      sum = CH_ETX;
      repeat ($urandom_range(0, 12)) begin
        c = CHAR_W'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
          0:       c = CH_STX;
          1:       c = CH_NAK;
          default: ;
        endcase
        if (c == CH_ETX) c = 7'h7F;
        q.push_back(c);
        sum = sum + c;
      end
      // steer the sum onto a bcc that owes trailing etx
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 2))
          0:       target = CH_AT;
          1:       target = CH_STAR;
          default: target = CH_DOT;
        endcase
        c = target - sum;
        if (c == CH_ETX) begin
          q.push_back(7'h01);
          sum = sum + 7'h01;
          c   = target - sum;
        end
        q.push_back(c);
        sum = sum + c;
      end
      if (mode < 88) begin
        q.push_back(CH_ETX);
        bcc = sum;
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0:       bcc = CH_AT;
            1:       bcc = CH_STAR;
            2:       bcc = CH_DOT;
            default: bcc = CHAR_W'($urandom_range(0, 127));
          endcase
        end
        q.push_back(bcc);
        if (bcc == CH_AT) pads = int'(PAD_SHORT);
        else if (bcc == CH_STAR || bcc == CH_DOT) pads = int'(PAD_LONG);
        else pads = 0;
        repeat (pads) begin
          c = CH_ETX;
          if ($urandom_range(0, 19) == 0) c = CHAR_W'($urandom_range(0, 127));
          q.push_back(c);
        end
      end
    end
  endtask

  task test_hunting_chars();
    send_chars({CH_NAK, 7'h7F, 7'h00, CH_ETX, CH_AT});
  endtask

  task test_directed_frames();
    // stx and nak inside the body are plain body chars
    send_chars({CH_STX, 7'h7F, CH_NAK, CH_STX, 7'h00, CH_ETX, 7'h19});
    // empty body, wrong check
    send_chars({CH_STX, CH_ETX, 7'h04});
    // '@' check with its three trailing etx
    send_chars({CH_STX, 7'h3D, CH_ETX, CH_AT, CH_ETX, CH_ETX, CH_ETX});
    // stx where an etx is owed is consumed, then hunting again
    send_chars({CH_STX, CH_ETX, CH_STAR, CH_ETX, CH_STX, CH_NAK});
    send_chars({CH_STX, CH_ETX, CH_DOT, CH_ETX, CH_ETX, CH_ETX, CH_ETX, CH_ETX, CH_ETX,
                CH_ETX, CH_ETX, CH_ETX});
  endtask

  task test_random_traffic(input int n);
    char_q_t q;
    int      stop_at;
    stop_at = chars_sent + n;
    while (chars_sent < stop_at) begin
      gen_frame(q);
      send_chars(q);
    end
  endtask

  task test_back_to_back(input int n);
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    test_random_traffic(n);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    test_hunting_chars();
    test_directed_frames();
    test_random_traffic(1650);
    test_back_to_back(220);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d characters: %0d body chars, %0d good frames, %0d bcc mismatches",
             chars_sent, events_seen[EV_BODY], events_seen[EV_GOOD], events_seen[EV_MISMATCH]);
    $display("  %0d missing trailing etx, %0d naks while hunting",
             events_seen[EV_NOETX], events_seen[EV_NAK]);
    if (mismatch_count == 0) begin
      $display("tb_stx_etx_bcc_frame_checker passed");
    end else begin
      $display("tb_stx_etx_bcc_frame_checker failed");
    end
    $finish;
  end

endmodule

// ===== stx_etx_bcc_frame_checker.f =====
+incdir+rtl/core
rtl/core/sebfc_pkg.sv
rtl/core/sebfc_fsm.sv
rtl/core/stx_etx_bcc_frame_checker.sv
tb/tb_stx_etx_bcc_frame_checker.sv
